// ----- design/hpd_pkg.sv -----
// ----------------------------------------------------------------------------
// hpd_pkg
// Shared types, result codes and the canonical code tables for the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hpd_pkg;

	localparam int MaxCodeLen = 30;
	localparam int NumCodes   = 257;
	localparam int BufW       = 37;
	localparam int CntW       = 6;
	localparam int LenW       = 5;
	localparam int IdxW       = 9;

	localparam logic [1:0] KIND_SYM = 2'd0;
	localparam logic [1:0] KIND_END = 2'd1;
	localparam logic [1:0] KIND_ERR = 2'd2;

	// EOS is the 30-bit code with the highest symbol value, so it sorts last
	localparam logic [IdxW-1:0] EOS_IDX = 9'd256;

	localparam logic [LenW-1:0] CODE_LEN [0:NumCodes-1] = '{
		13,23,28,28,28,28,28,28,28,24,30,28,28,30,28,28,
		28,28,28,28,28,28,30,28,28,28,28,28,28,28,28,28,
		 6,10,10,12,13, 6, 8,11,10,10, 8,11, 8, 6, 6, 6,
		 5, 5, 5, 6, 6, 6, 6, 6, 6, 6, 7, 8,15, 6,12,10,
		13, 6, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7,
		 7, 7, 7, 7, 7, 7, 7, 7, 8, 7, 8,13,19,13,14, 6,
		15, 5, 6, 5, 6, 5, 6, 6, 6, 5, 7, 7, 6, 6, 6, 5,
		 6, 7, 6, 5, 5, 6, 7, 7, 7, 7, 7,15,11,14,13,28,
		20,22,20,20,22,22,22,23,22,23,23,23,23,23,24,23,
		24,24,22,23,24,23,23,23,23,21,22,23,22,23,23,24,
		22,21,20,22,22,23,23,21,23,22,22,24,21,22,23,23,
		21,21,22,21,23,22,23,23,20,22,22,22,23,22,22,23,
		26,26,20,19,22,23,22,25,26,26,26,27,27,26,24,25,
		19,21,26,27,27,26,27,24,21,21,26,26,28,27,27,27,
		20,24,20,21,22,21,21,23,22,22,25,25,24,24,26,23,
		26,27,26,26,27,27,27,27,27,28,27,27,27,27,27,26,
		30
	};

	typedef logic [31:0][MaxCodeLen-1:0] first_tab_t;
	typedef logic [31:0][IdxW-1:0]       num_tab_t;
	typedef logic [NumCodes-1:0][IdxW-1:0] sym_tab_t;

	typedef struct packed {
		logic            push;
		logic [1:0]      kind;
		logic [IdxW-1:0] idx;
		logic            run_end;
	} hpd_push_t;

	function automatic int len_count(input int len);
		int n;
		n = 0;
		for (int s = 0; s < NumCodes; s++) begin
			if (int'(CODE_LEN[s]) == len) n++;
		end
		return n;
	endfunction

	function automatic first_tab_t build_first();
		first_tab_t t;
		longint nxt;
		t = '0;
		nxt = 0;
		for (int l = 1; l <= MaxCodeLen; l++) begin
			t[l] = nxt[MaxCodeLen-1:0];
			nxt = (nxt + longint'(len_count(l))) << 1;
		end
		return t;
	endfunction

	function automatic num_tab_t build_count();
		num_tab_t t;
		t = '0;
		for (int l = 1; l <= MaxCodeLen; l++) t[l] = IdxW'(len_count(l));
		return t;
	endfunction

	function automatic num_tab_t build_offset();
		num_tab_t t;
		int acc;
		t = '0;
		acc = 0;
		for (int l = 1; l <= MaxCodeLen; l++) begin
			t[l] = IdxW'(acc);
			acc = acc + len_count(l);
		end
		return t;
	endfunction

	function automatic sym_tab_t build_syms();
		sym_tab_t t;
		int k;
		t = '0;
		k = 0;
		for (int l = 1; l <= MaxCodeLen; l++) begin
			for (int s = 0; s < NumCodes; s++) begin
				if (int'(CODE_LEN[s]) == l) begin
					t[k] = IdxW'(s);
					k++;
				end
			end
		end
		return t;
	endfunction

	localparam first_tab_t FIRST_CODE = build_first();
	localparam num_tab_t   CODE_COUNT = build_count();
	localparam num_tab_t   CODE_BASE  = build_offset();
	localparam sym_tab_t   SYM_ROM    = build_syms();

	// ones in every bit below cnt
	function automatic logic [BufW-1:0] low_mask(input logic [CntW-1:0] cnt);
		logic [BufW-1:0] m;
		for (int i = 0; i < BufW; i++) m[i] = (CntW'(i) < cnt);
		return m;
	endfunction

endpackage

`default_nettype wire

// ----- design/hpd_if.sv -----
// ----------------------------------------------------------------------------
// hpd_in_if / hpd_out_if
// Valid/ready channels carrying coded bytes in and decode results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface hpd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       last_byte;
	modport source (output valid, in_byte, last_byte, input ready);
	modport sink   (input valid, in_byte, last_byte, output ready);
endinterface

interface hpd_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] symbol;
	logic       run_end;
	modport source (output valid, kind, symbol, run_end, input ready);
	modport sink   (input valid, kind, symbol, run_end, output ready);
endinterface

`default_nettype wire

// ----- design/hpack_huffman_decoder.sv -----
// ----------------------------------------------------------------------------
// hpack_huffman_decoder
// HPACK Huffman string decoder, bit-serial walk of the canonical code.
// ----------------------------------------------------------------------------
// Operation: a byte is accepted in idle, then the pending bits are walked one
//   bit per cycle. Each symbol found is given in its own state, which waits for
//   a free output slot. The end state follows when the bits run out, or straight
//   after a second symbol. A new byte is accepted only back in idle, so bytes do
//   not overlap. Results leave through one output register.
// Reset: arst_n clears the bit buffer, counters, discard flag and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module hpack_huffman_decoder (
	input  wire logic  clk,
	input  wire logic  arst_n,
	hpd_in_if.sink     in_ch,
	hpd_out_if.source  out_ch
);
	import hpd_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_WALK = 3'd1;
	localparam logic [2:0] ST_SYM  = 3'd2;
	localparam logic [2:0] ST_END  = 3'd3;

	logic [2:0]            state_q;
	logic [BufW-1:0]       buf_q;      // pending bits, right aligned
	logic [CntW-1:0]       cnt_q;      // pending bit count
	logic [MaxCodeLen-1:0] code_q;     // code word walked so far from the head
	logic [LenW-1:0]       len_q;      // its length
	logic                  nmatch_q;   // one symbol already given this beat
	logic                  last_q;
	logic                  disc_q;     // dropping beats after an error
	logic [LenW-1:0]       hit_len_q;
	logic [IdxW-1:0]       hit_idx_q;

	logic                  slot_free;
	hpd_push_t             push;

	logic [CntW-1:0]       bit_pos;
	logic [MaxCodeLen-1:0] code_nx;
	logic [LenW-1:0]       len_nx;
	logic                  hit;
	logic [IdxW-1:0]       hit_idx;
	logic [CntW-1:0]       cnt_left;
	logic                  pad_ok;
	logic                  have_bits;
	logic                  drop_old;

	// next bit to walk sits len bits below the buffer head
	assign bit_pos   = cnt_q - CntW'(1) - CntW'(len_q);
	assign code_nx   = {code_q[MaxCodeLen-2:0], buf_q[bit_pos]};
	assign len_nx    = len_q + LenW'(1);
	assign have_bits = CntW'(len_q) < cnt_q;
	assign cnt_left  = cnt_q - CntW'(hit_len_q);
	// padding: at most seven bits, all ones
	assign pad_ok    = (cnt_q <= CntW'(7)) && (buf_q == low_mask(cnt_q));
	// more than 29 unmatched bits are thrown away on the next byte
	assign drop_old  = cnt_q > CntW'(29);

	assign in_ch.ready = (state_q == ST_IDLE);

	hpd_match u_match (
		.code (code_nx),
		.len  (len_nx),
		.hit  (hit),
		.idx  (hit_idx)
	);

	always_comb begin
		push = '0;
		push.idx = hit_idx_q;
		case (state_q)
			ST_SYM: begin
				if (slot_free) begin
					push.push    = 1'b1;
					push.kind    = (hit_idx_q == EOS_IDX) ? KIND_ERR : KIND_SYM;
					push.run_end = (hit_idx_q == EOS_IDX);
				end
			end
			ST_END: begin
				if (last_q && slot_free) begin
					push.push    = 1'b1;
					push.kind    = pad_ok ? KIND_END : KIND_ERR;
					push.run_end = 1'b1;
				end
			end
			default: push = push;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			buf_q     <= '0;
			cnt_q     <= '0;
			code_q    <= '0;
			len_q     <= '0;
			nmatch_q  <= 1'b0;
			last_q    <= 1'b0;
			disc_q    <= 1'b0;
			hit_len_q <= '0;
			hit_idx_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						if (disc_q) begin
							// the last beat of a failed string ends the discard
							if (in_ch.last_byte) begin
								disc_q <= 1'b0;
								buf_q  <= '0;
								cnt_q  <= '0;
								code_q <= '0;
								len_q  <= '0;
							end
						end else begin
							if (drop_old) begin
								buf_q  <= {29'd0, in_ch.in_byte};
								cnt_q  <= CntW'(8);
								code_q <= '0;
								len_q  <= '0;
							end else begin
								buf_q <= {buf_q[BufW-9:0], in_ch.in_byte};
								cnt_q <= cnt_q + CntW'(8);
							end
							last_q   <= in_ch.last_byte;
							nmatch_q <= 1'b0;
							state_q  <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (have_bits) begin
						code_q <= code_nx;
						len_q  <= len_nx;
						if (hit) begin
							hit_len_q <= len_nx;
							hit_idx_q <= hit_idx;
							state_q   <= ST_SYM;
						end
					end else begin
						state_q <= ST_END;
					end
				end
				ST_SYM: begin
					if (slot_free) begin
						code_q <= '0;
						len_q  <= '0;
						if (hit_idx_q == EOS_IDX) begin
							// EOS inside the data
							buf_q   <= '0;
							cnt_q   <= '0;
							disc_q  <= !last_q;
							state_q <= ST_IDLE;
						end else begin
							cnt_q    <= cnt_left;
							buf_q    <= buf_q & low_mask(cnt_left);
							nmatch_q <= 1'b1;
							state_q  <= nmatch_q ? ST_END : ST_WALK;
						end
					end
				end
				ST_END: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (slot_free) begin
						buf_q   <= '0;
						cnt_q   <= '0;
						code_q  <= '0;
						len_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	hpd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.slot_free (slot_free),
		.out_ch    (out_ch)
	);
endmodule

`default_nettype wire

// ----- design/hpd_match.sv -----
// ----------------------------------------------------------------------------
// hpd_match
// Canonical code check: is the partial code word a complete code of its length.
// ----------------------------------------------------------------------------
`default_nettype none

module hpd_match (
	input  wire logic [hpd_pkg::MaxCodeLen-1:0] code,
	input  wire logic [hpd_pkg::LenW-1:0]       len,
	output logic                                hit,
	output logic [hpd_pkg::IdxW-1:0]            idx
);
	import hpd_pkg::*;

	logic [MaxCodeLen-1:0] diff;

	always_comb begin
		diff = code - FIRST_CODE[len];
		hit  = (code >= FIRST_CODE[len]) && (diff < MaxCodeLen'(CODE_COUNT[len]));
		idx  = CODE_BASE[len] + diff[IdxW-1:0];
	end
endmodule

`default_nettype wire

// ----- design/hpd_out_stage.sv -----
// ----------------------------------------------------------------------------
// hpd_out_stage
// Result register; looks up the decoded symbol in the sorted symbol ROM.
// ----------------------------------------------------------------------------
`default_nettype none

module hpd_out_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire hpd_pkg::hpd_push_t push,
	output logic                   slot_free,
	hpd_out_if.source              out_ch
);
	import hpd_pkg::*;

	logic            valid_q;
	logic [1:0]      kind_q;
	logic [7:0]      symbol_q;
	logic            run_end_q;
	logic [IdxW-1:0] rom_sym;

	assign slot_free = !valid_q || out_ch.ready;
	assign rom_sym   = SYM_ROM[push.idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push.push) begin
			valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push.push) begin
			kind_q    <= push.kind;
			symbol_q  <= (push.kind == KIND_SYM) ? rom_sym[7:0] : 8'd0;
			run_end_q <= push.run_end;
		end
	end

	assign out_ch.valid   = valid_q;
	assign out_ch.kind    = kind_q;
	assign out_ch.symbol  = symbol_q;
	assign out_ch.run_end = run_end_q;
endmodule

`default_nettype wire
